FILE: rtl/cpr_pkg.sv
package cpr_pkg;

  localparam int unsigned PAGE_W          = 16;
  localparam int unsigned SLOT_W          = 6;
  localparam int unsigned CFG_W           = 7;
  localparam int unsigned MAX_FRAMES_DEF  = 64;
  localparam int unsigned PAGE_BITS_DEF   = 16;
  localparam int unsigned FRAMES_RST      = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_EVICT,
    ST_FINISH
  } cpr_state_e;

  typedef struct packed {
    logic              fault;
    logic [SLOT_W-1:0] frame_slot;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
  } cpr_result_t;

endpackage

FILE: rtl/cpr_page_ram.sv
module cpr_page_ram #(
  parameter int unsigned DEPTH = cpr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned WIDTH = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  import cpr_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cpr_ctrl.sv
module cpr_ctrl #(
  parameter int unsigned MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clear_i,
  input  logic [$clog2(MAX_FRAMES+1)-1:0]   n_frames_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cpr_pkg::PAGE_W-1:0]        page_number_i,
  input  logic                              out_free_i,
  output logic                              res_valid_o,
  output cpr_pkg::cpr_result_t              res_o
);
  import cpr_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);

  function automatic logic [IDX_W-1:0] next_frame(input logic [IDX_W-1:0] p,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(p) + CNT_W'(1);
    return (inc >= n) ? '0 : inc[IDX_W-1:0];
  endfunction

  cpr_state_e            state_q, state_d;
  logic [PAGE_BITS-1:0]  page_q, page_d;
  logic [IDX_W-1:0]      hand_q, hand_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                  cmp_last_q, cmp_last_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  logic                  fault_q, fault_d;
  logic [MAX_FRAMES-1:0] valid_q, valid_d;
  logic [MAX_FRAMES-1:0] use_q, use_d;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_raddr;
  logic [PAGE_BITS-1:0]  mem_rdata;
  logic                  cmp_hit;

  cpr_page_ram #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (PAGE_BITS)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_q),
    .wdata_i (page_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign mem_raddr = (state_q == ST_SCAN) ? idx_q[IDX_W-1:0] : slot_q;
  assign cmp_hit   = cmp_vld_q && valid_q[cmp_idx_q] && (mem_rdata == page_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hand_q    <= '0;
      cmp_vld_q <= 1'b0;
      valid_q   <= '0;
      use_q     <= '1;
    end else begin
      state_q   <= state_d;
      hand_q    <= hand_d;
      cmp_vld_q <= cmp_vld_d;
      valid_q   <= valid_d;
      use_q     <= use_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    cmp_last_q <= cmp_last_d;
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    slot_q     <= slot_d;
    fault_q    <= fault_d;
  end

  always_comb begin
    state_d     = state_q;
    page_d      = page_q;
    hand_d      = hand_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    cmp_last_d  = cmp_last_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    fault_d     = fault_q;
    valid_d     = valid_q;
    use_d       = use_q;
    mem_we      = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          page_d  = PAGE_BITS'(page_number_i);
          hand_d  = (CNT_W'(hand_q) >= n_frames_i) ? '0 : hand_q;
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one table read per cycle, compare the previous one
        idx_d      = idx_q + CNT_W'(1);
        cmp_vld_d  = 1'b1;
        cmp_idx_d  = idx_q[IDX_W-1:0];
        cmp_last_d = ((idx_q + CNT_W'(1)) == n_frames_i);
        if (cmp_hit) begin
          cmp_vld_d = 1'b0;
          fault_d   = 1'b0;
          slot_d    = cmp_idx_q;
          state_d   = ST_FINISH;
        end else if (cmp_vld_q && cmp_last_q) begin
          cmp_vld_d = 1'b0;
          pos_d     = hand_q;
          cnt_d     = '0;
          state_d   = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        fault_d = 1'b1;
        if (!use_q[pos_q]) begin
          slot_d  = pos_q;
          state_d = ST_EVICT;
        end else begin
          use_d[pos_q] = 1'b0;
          if (cnt_q == n_frames_i - CNT_W'(1)) begin
            // full turn without a clear bit: take the starting frame
            slot_d  = hand_q;
            state_d = ST_EVICT;
          end else begin
            pos_d = next_frame(pos_q, n_frames_i);
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_EVICT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          res_valid_o      = 1'b1;
          res_o.fault      = fault_q;
          res_o.frame_slot = SLOT_W'(slot_q);
          use_d[slot_q]    = 1'b1;
          if (fault_q) begin
            res_o.evicted_valid = valid_q[slot_q];
            res_o.evicted_page  = valid_q[slot_q] ? PAGE_W'(mem_rdata) : '0;
            mem_we              = 1'b1;
            valid_d[slot_q]     = 1'b1;
            hand_d              = next_frame(slot_q, n_frames_i);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (clear_i) begin
      valid_d = '0;
      use_d   = '1;
      hand_d  = '0;
    end
  end

endmodule

FILE: rtl/clock_page_replacement_core.sv
// Clock (second-chance) page replacement engine.
// Input channel (in_valid_i / in_ready_o) carries one page number per beat.
// Output channel (out_valid_o / out_ready_i) returns one beat per request:
// fault flag, frame slot holding the page, and the evicted page if any.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes frames_in_use;
// it is always ready, and every write empties the table and parks the hand
// at frame 0. Values of 0 act as 1, values above MAX_FRAMES as MAX_FRAMES.
// One request is handled at a time: the lookup reads the page table one
// frame per cycle and ends early on a hit; a miss then sweeps the use bits
// one frame per cycle, over up to n active frames, and then goes through the
// eviction read and the load. The next request is taken in the cycle after
// a result is produced.
// A finished result sits in the output register; the next request is taken
// meanwhile, and its own result waits until the receiver drains the first.
// Reset empties the table, sets all use bits, parks the hand at frame 0 and
// sets the frame count to 64 (bounded by MAX_FRAMES). Page contents have no
// reset; they are only read for frames marked valid.
module clock_page_replacement_core #(
  parameter int unsigned MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cpr_pkg::CFG_W-1:0]  frames_in_use_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cpr_pkg::PAGE_W-1:0] page_number_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       fault_o,
  output logic [cpr_pkg::SLOT_W-1:0] frame_slot_o,
  output logic                       evicted_valid_o,
  output logic [cpr_pkg::PAGE_W-1:0] evicted_page_o
);
  import cpr_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned N_RESET = (FRAMES_RST > MAX_FRAMES) ? MAX_FRAMES : FRAMES_RST;

  logic [CNT_W-1:0] n_q, n_d;
  logic             cfg_we;
  logic             out_valid_q, out_valid_d;
  cpr_result_t      res_q;
  cpr_result_t      res;
  logic             res_valid;
  logic             out_free;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    n_d = n_q;
    if (cfg_we) begin
      if (frames_in_use_i == '0) begin
        n_d = CNT_W'(1);
      end else if (32'(frames_in_use_i) > MAX_FRAMES) begin
        n_d = CNT_W'(MAX_FRAMES);
      end else begin
        n_d = CNT_W'(frames_in_use_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= CNT_W'(N_RESET);
    end else begin
      n_q <= n_d;
    end
  end

  cpr_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (cfg_we),
    .n_frames_i    (n_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .page_number_i (page_number_i),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fault_o         = res_q.fault;
  assign frame_slot_o    = res_q.frame_slot;
  assign evicted_valid_o = res_q.evicted_valid;
  assign evicted_page_o  = res_q.evicted_page;

  a_res_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result produced while output register is occupied");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one is in progress");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res.fault) |-> (!res.evicted_valid && (res.evicted_page == '0)))
    else $error("hit reported with an eviction");

  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q != '0) && (32'(n_q) <= MAX_FRAMES))
    else $error("active frame count out of range");

endmodule
